// ----- rtl/rsgs_pkg.sv -----
package rsgs_pkg;

    localparam int BYTE_FIELDS = 4;
    localparam int BYTE_W      = 8;
    localparam int SUM_W       = BYTE_W + $clog2(BYTE_FIELDS);
    localparam int GAIN_W      = 8;
    localparam int OUT_W       = 32;
    localparam int QUOT_W      = 16;
    localparam int SCORE_W     = QUOT_W + 1;
    localparam int ITER_W      = $clog2(QUOT_W);

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 8'd5;
    localparam logic [SCORE_W-1:0] SCORE_ONE  = 17'h10000;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_0;
        logic [BYTE_W-1:0] byte_1;
        logic [BYTE_W-1:0] byte_2;
        logic [BYTE_W-1:0] byte_3;
        logic              last;
    } grp_t;

    typedef struct packed {
        logic [OUT_W-1:0]   group_count;
        logic [OUT_W-1:0]   regular_count;
        logic [OUT_W-1:0]   singular_count;
        logic [OUT_W-1:0]   regular_flipped_count;
        logic [OUT_W-1:0]   singular_flipped_count;
        logic [SCORE_W-1:0] score;
    } res_t;

    // differences of one neighbouring pair, plain and with both LSBs flipped
    typedef struct packed {
        logic [BYTE_W-1:0] diff_plain;
        logic [BYTE_W-1:0] diff_flip;
    } lane_t;

    typedef struct packed {
        logic regular;
        logic singular;
    } cls_t;

    typedef struct packed {
        logic idle;
        logic done;
    } score_ctl_t;

endpackage

// ----- rtl/rsgs_lane.sv -----
module rsgs_lane (
    input  logic [rsgs_pkg::BYTE_W-1:0] byte_a,
    input  logic [rsgs_pkg::BYTE_W-1:0] byte_b,
    output rsgs_pkg::lane_t             lane
);
    import rsgs_pkg::*;

    logic [BYTE_W-1:0] fa;
    logic [BYTE_W-1:0] fb;

    assign fa = {byte_a[BYTE_W-1:1], ~byte_a[0]};
    assign fb = {byte_b[BYTE_W-1:1], ~byte_b[0]};

    always_comb
    begin
        lane.diff_plain = (byte_a > byte_b) ? byte_a - byte_b : byte_b - byte_a;
        lane.diff_flip  = (fa > fb) ? fa - fb : fb - fa;
    end

endmodule

// ----- rtl/rsgs_merge.sv -----
module rsgs_merge #(
    parameter int NUM_LANES = 3
) (
    input  rsgs_pkg::lane_t [NUM_LANES-1:0] lanes,
    output rsgs_pkg::cls_t                  cls
);
    import rsgs_pkg::*;

    logic [SUM_W-1:0] f_plain;
    logic [SUM_W-1:0] f_flip;

    always_comb
    begin
        f_plain = '0;
        f_flip  = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            f_plain = f_plain + SUM_W'(lanes[i].diff_plain);
            f_flip  = f_flip + SUM_W'(lanes[i].diff_flip);
        end
        cls.regular  = f_flip > f_plain;
        cls.singular = f_flip < f_plain;
    end

endmodule

// ----- rtl/rsgs_score.sv -----
module rsgs_score #(
    parameter int CW = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [CW-1:0]               n_in,
    input  logic [CW-1:0]               r_in,
    input  logic [CW-1:0]               s_in,
    input  logic [CW-1:0]               rf_in,
    input  logic [CW-1:0]               sf_in,
    input  logic [rsgs_pkg::GAIN_W-1:0] gain,
    input  logic                        take,
    output rsgs_pkg::score_ctl_t        ctl,
    output rsgs_pkg::res_t              result
);
    import rsgs_pkg::*;

    localparam int NUM_W  = CW + 1;
    localparam int PROD_W = NUM_W + GAIN_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NUM  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [CW-1:0]       n_reg, r_reg, s_reg, rf_reg, sf_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [CW:0]         rem_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [SCORE_W-1:0]  score_reg;

    logic [NUM_W-1:0]    part_r, part_s;
    logic [CW:0]         rem_sh;
    logic                q_bit;

    always_comb
    begin
        part_r = (r_reg > rf_reg) ? NUM_W'(r_reg - rf_reg) : '0;
        part_s = (sf_reg > s_reg) ? NUM_W'(sf_reg - s_reg) : '0;
        rem_sh = {rem_reg[CW-1:0], 1'b0};
        q_bit  = rem_sh >= {1'b0, n_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_CMP;
            ST_CMP:
            begin
                iter_next = '0;
                if (prod_reg >= PROD_W'(n_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(QUOT_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            n_reg  <= n_in;
            r_reg  <= r_in;
            s_reg  <= s_in;
            rf_reg <= rf_in;
            sf_reg <= sf_in;
        end
        if (state_reg == ST_NUM)
        begin
            num_reg <= part_r + part_s;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= num_reg * PROD_W'(gain);
        end
        if (state_reg == ST_CMP)
        begin
            // prod < n whenever the divider runs next, so it then fits the remainder
            rem_reg   <= {1'b0, prod_reg[CW-1:0]};
            quot_reg  <= '0;
            score_reg <= SCORE_ONE;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg   <= q_bit ? rem_sh - {1'b0, n_reg} : rem_sh;
            quot_reg  <= {quot_reg[QUOT_W-2:0], q_bit};
            score_reg <= {1'b0, quot_reg[QUOT_W-2:0], q_bit};
        end
    end

    assign ctl.idle = state_reg == ST_IDLE;
    assign ctl.done = state_reg == ST_DONE;

    always_comb
    begin
        result.group_count            = OUT_W'(n_reg);
        result.regular_count          = OUT_W'(r_reg);
        result.singular_count         = OUT_W'(s_reg);
        result.regular_flipped_count  = OUT_W'(rf_reg);
        result.singular_flipped_count = OUT_W'(sf_reg);
        result.score                  = score_reg;
    end

endmodule

// ----- rtl/lsb_group_regular_singular_stats.sv -----
// Channel  | Signals                          | Direction
// ---------+----------------------------------+----------
// group    | grp_valid, grp_ready, grp        | in
// result   | res_valid, res_ready, res        | out
// config   | cfg_wr_en, cfg_wr_data           | in
//
// A group that is not last is counted in the cycle it transfers, one per cycle
// while grp_ready is high. A last group starts the score unit (numerator, multiply,
// compare, restoring divider when the score is below 1.0), then the output register.
// grp_ready is low from a last group's transfer until its result moves to the
// output register, which waits while an earlier result there has not transferred.
// Reset clears all counters and sets gain_reg to 5.
module lsb_group_regular_singular_stats #(
    parameter int GROUP_SIZE  = 4,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rsgs_pkg::GAIN_W-1:0] cfg_wr_data,
    input  logic                        grp_valid,
    output logic                        grp_ready,
    input  rsgs_pkg::grp_t              grp,
    output logic                        res_valid,
    input  logic                        res_ready,
    output rsgs_pkg::res_t              res
);
    import rsgs_pkg::*;

    localparam int GROUP_LEN = (GROUP_SIZE < BYTE_FIELDS) ? GROUP_SIZE : BYTE_FIELDS;
    localparam int NUM_LANES = GROUP_LEN - 1;
    localparam int CW        = COUNT_WIDTH;

    logic [BYTE_W-1:0]       grp_bytes [BYTE_FIELDS];
    lane_t [NUM_LANES-1:0]   lanes;
    cls_t                    cls;
    score_ctl_t              sc_ctl;
    res_t                    sc_result;

    logic [GAIN_W-1:0] gain_reg;
    logic [CW-1:0]     n_reg, r_reg, s_reg, rf_reg, sf_reg;
    logic [CW-1:0]     n_inc, r_inc, s_inc, rf_inc, sf_inc;
    logic              grp_xfer;
    logic              take;
    logic              res_valid_reg;
    res_t              res_reg;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c == {CW{1'b1}}) ? c : c + 1'b1;
    endfunction

    assign grp_bytes[0] = grp.byte_0;
    assign grp_bytes[1] = grp.byte_1;
    assign grp_bytes[2] = grp.byte_2;
    assign grp_bytes[3] = grp.byte_3;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        rsgs_lane u_lane (
            .byte_a (grp_bytes[i]),
            .byte_b (grp_bytes[i+1]),
            .lane   (lanes[i])
        );
    end

    rsgs_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .lanes (lanes),
        .cls   (cls)
    );

    assign grp_ready = sc_ctl.idle;
    assign grp_xfer  = grp_valid && grp_ready;

    // second tally swaps roles: flipped-back group is regular when the original is singular
    always_comb
    begin
        n_inc  = sat_inc(n_reg);
        r_inc  = cls.regular  ? sat_inc(r_reg)  : r_reg;
        s_inc  = cls.singular ? sat_inc(s_reg)  : s_reg;
        rf_inc = cls.singular ? sat_inc(rf_reg) : rf_reg;
        sf_inc = cls.regular  ? sat_inc(sf_reg) : sf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            gain_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg  <= '0;
            r_reg  <= '0;
            s_reg  <= '0;
            rf_reg <= '0;
            sf_reg <= '0;
        end
        else if (grp_xfer)
        begin
            if (grp.last)
            begin
                n_reg  <= '0;
                r_reg  <= '0;
                s_reg  <= '0;
                rf_reg <= '0;
                sf_reg <= '0;
            end
            else
            begin
                n_reg  <= n_inc;
                r_reg  <= r_inc;
                s_reg  <= s_inc;
                rf_reg <= rf_inc;
                sf_reg <= sf_inc;
            end
        end
    end

    rsgs_score #(
        .CW (CW)
    ) u_score (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (grp_xfer && grp.last),
        .n_in   (n_inc),
        .r_in   (r_inc),
        .s_in   (s_inc),
        .rf_in  (rf_inc),
        .sf_in  (sf_inc),
        .gain   (gain_reg),
        .take   (take),
        .ctl    (sc_ctl),
        .result (sc_result)
    );

    assign take = sc_ctl.done && (!res_valid_reg || res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= sc_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
